// ===== rtl/crc16fw_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16fw_pkg
// Shared widths, register codes, types and helpers of the framed CRC-16
// word checker.
// ----------------------------------------------------------------------------
package crc16fw_pkg;

  // Frame bits consumed per input word.
  localparam int WORD_BITS  = 32;
  // Width of the data_word field.
  localparam int DATA_W     = 32;
  localparam int CRC_W      = 16;
  // Width of the bit counter and of the frame length register.
  localparam int POS_W      = 16;
  // One more bit so that a frame of 65536 bits can be represented.
  localparam int LEN_W      = POS_W + 1;

  localparam logic [CRC_W-1:0] POLY_TAPS = 16'h1021;
  localparam int               EDGE_LEN  = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_EDGES   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_RESULT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_RESULT = 8'd3;

  localparam logic [POS_W-1:0] FRAME_BITS_RST = 16'd32;

  typedef struct packed {
    logic [POS_W-1:0] frame_bits;
    logic             invert_edges;
    logic             invert_result;
    logic             reverse_result;
  } cfg_t;

  // What the engine makes of the word now in the input register.
  typedef struct packed {
    logic             emit;
    logic [CRC_W-1:0] crc;
  } eng_res_t;

  function automatic logic [CRC_W-1:0] reverse16(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/crc16fw_word_if.sv =====
// ----------------------------------------------------------------------------
// crc16fw_word_if
// Input word channel: valid/ready plus one frame word.
// ----------------------------------------------------------------------------
interface crc16fw_word_if;
  logic                          valid;
  logic                          ready;
  logic [crc16fw_pkg::DATA_W-1:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

// ===== rtl/crc16fw_crc_if.sv =====
// ----------------------------------------------------------------------------
// crc16fw_crc_if
// Result channel: valid/ready plus one 16-bit CRC value.
// ----------------------------------------------------------------------------
interface crc16fw_crc_if;
  logic                          valid;
  logic                          ready;
  logic [crc16fw_pkg::CRC_W-1:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// ===== rtl/crc16fw_cfg_if.sv =====
// ----------------------------------------------------------------------------
// crc16fw_cfg_if
// Configuration write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface crc16fw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [crc16fw_pkg::CFG_IDX_W-1:0]  index;
  logic [crc16fw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/crc16fw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// crc16fw_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module crc16fw_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  crc16fw_cfg_if.sink         cfg_chan,
  output crc16fw_pkg::cfg_t   cfg
);

  crc16fw_pkg::cfg_t cfg_next;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        crc16fw_pkg::REG_FRAME_BITS:
          cfg_next.frame_bits = cfg_chan.data[crc16fw_pkg::POS_W-1:0];
        crc16fw_pkg::REG_INVERT_EDGES:   cfg_next.invert_edges   = cfg_chan.data[0];
        crc16fw_pkg::REG_INVERT_RESULT:  cfg_next.invert_result  = cfg_chan.data[0];
        crc16fw_pkg::REG_REVERSE_RESULT: cfg_next.reverse_result = cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_bits     <= crc16fw_pkg::FRAME_BITS_RST;
      cfg.invert_edges   <= 1'b1;
      cfg.invert_result  <= 1'b1;
      cfg.reverse_result <= 1'b0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== rtl/crc16fw_engine.sv =====
// ----------------------------------------------------------------------------
// crc16fw_engine
// CRC state and bit counter with a one-word unrolled shift update.
// ----------------------------------------------------------------------------
module crc16fw_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  crc16fw_pkg::cfg_t                cfg,
  input  logic [crc16fw_pkg::DATA_W-1:0]   data_word,
  input  logic                             fire,
  output crc16fw_pkg::eng_res_t            res
);

  localparam int WB  = crc16fw_pkg::WORD_BITS;
  localparam int CW  = crc16fw_pkg::CRC_W;
  localparam int PW  = crc16fw_pkg::POS_W;
  localparam int LW  = crc16fw_pkg::LEN_W;

  logic [CW-1:0] shift_stages;
  logic [PW-1:0] bit_position;

  logic [LW-1:0] frame_len;
  logic [WB-1:0] word_ext;
  logic [LW-1:0] lane_pos [WB];
  logic [WB-1:0] lane_inv;
  logic [WB-1:0] lane_end;
  logic [WB-1:0] lane_bit;
  logic [CW-1:0] chain [WB+1];
  logic          done;
  logic [CW-1:0] crc_raw;

  // Zero length register means 65536 bits.
  assign frame_len = (cfg.frame_bits == '0) ? (LW'(1) << PW) : LW'(cfg.frame_bits);
  assign word_ext  = WB'(data_word);

  // Each lane is one frame bit; lanes past the frame end leave the state alone.
  always_comb begin
    chain[0] = shift_stages;
    done     = 1'b0;
    for (int k = 0; k < WB; k++) begin
      lane_pos[k] = LW'(bit_position) + LW'(k);
      lane_inv[k] = cfg.invert_edges &&
                    ((lane_pos[k] < LW'(crc16fw_pkg::EDGE_LEN)) ||
                     ((lane_pos[k] + LW'(crc16fw_pkg::EDGE_LEN)) >= frame_len));
      lane_end[k] = (lane_pos[k] + LW'(1)) >= frame_len;
      lane_bit[k] = word_ext[k] ^ lane_inv[k];
      if (done) begin
        chain[k+1] = chain[k];
      end else begin
        chain[k+1] = {chain[k][CW-2:0], lane_bit[k]} ^
                     (chain[k][CW-1] ? crc16fw_pkg::POLY_TAPS : '0);
      end
      done = done | lane_end[k];
    end
  end

  assign crc_raw  = chain[WB] ^ {CW{cfg.invert_result}};
  assign res.emit = |lane_end;
  assign res.crc  = cfg.reverse_result ? crc16fw_pkg::reverse16(crc_raw) : crc_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_stages <= '0;
      bit_position <= '0;
    end else if (fire) begin
      if (res.emit) begin
        shift_stages <= '0;
        bit_position <= '0;
      end else begin
        shift_stages <= chain[WB];
        bit_position <= bit_position + PW'(WB);
      end
    end
  end

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    fire && res.emit |=> shift_stages == '0 && bit_position == '0)
    else $error("engine state not cleared after frame end");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    fire && !res.emit |=> bit_position == $past(bit_position) + PW'(WB))
    else $error("bit counter did not advance by one word");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(shift_stages) && $stable(bit_position))
    else $error("engine state moved without a word");

endmodule

// ===== rtl/crc16_framed_word_checker_unit.sv =====
// ----------------------------------------------------------------------------
// crc16_framed_word_checker_unit
// Framed CRC-16 (x^16+x^12+x^5+1, augmented) checker over 32-bit words.
// ----------------------------------------------------------------------------
// Frame words arrive on data_chan, bit 0 first; frame_bits bits make a frame
// (0 means 65536) and the rest of the word that ends a frame is dropped. One
// word is taken every clock cycle unless a held result stalls the input. The
// word sits in an input register, the whole 32-bit shift update runs in one
// pass through the engine, and when a frame ends the CRC lands in the result
// register, which offers it on result_chan. The unrolled update between those
// two registers is combinational. A word that does not close a frame produces
// nothing. A held result only stalls the input when the next word would also
// end a frame. Configuration writes (frame_bits, invert_edges, invert_result,
// reverse_result at indexes 0..3) are always accepted and must be issued
// while no frame word is in flight.
// ----------------------------------------------------------------------------
module crc16_framed_word_checker_unit (
  input  logic           clk,
  input  logic           rst,
  crc16fw_cfg_if.sink    cfg_chan,
  crc16fw_word_if.sink   data_chan,
  crc16fw_crc_if.source  result_chan
);

  crc16fw_pkg::cfg_t     cfg;
  crc16fw_pkg::eng_res_t eng_res;

  // Input register.
  logic                           s1_valid;
  logic [crc16fw_pkg::DATA_W-1:0] s1_word;
  logic                           s1_adv;

  // Result register.
  logic                           out_valid;
  logic [crc16fw_pkg::CRC_W-1:0]  out_crc;

  crc16fw_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  crc16fw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .data_word (s1_word),
    .fire      (s1_adv),
    .res       (eng_res)
  );

  // The word moves on unless it ends a frame and the result slot stays full.
  assign s1_adv          = s1_valid && (!eng_res.emit || !out_valid || result_chan.ready);
  assign data_chan.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_chan.ready) begin
      s1_valid <= data_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_chan.valid && data_chan.ready) begin
      s1_word <= data_chan.data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && eng_res.emit) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && eng_res.emit) begin
      out_crc <= eng_res.crc;
    end
  end

  assign result_chan.valid     = out_valid;
  assign result_chan.crc_value = out_crc;

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv && eng_res.emit |=> out_valid && out_crc == $past(eng_res.crc))
    else $error("frame end did not load the result register");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_word))
    else $error("stalled input word lost or changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> eng_res.emit && out_valid && !result_chan.ready)
    else $error("input stalled without a blocked result");

endmodule
